// ===== design/assert_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on nothing; files that assert include it inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// The condition must never hold.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`endif

// ===== design/mfsd_pkg.sv =====
// Package for the marker-framed sample deframer: constants, command word type,
// and the FIR coefficient function. Depends on nothing.
`default_nettype none
package mfsd_pkg;
  localparam int TAPS            = 79;
  localparam int FILTER_CHANNELS = 4;
  localparam int COEF_FRAC_BITS  = 20;

  localparam int NUM_COEF  = 79;
  localparam int HALF_COEF = 40;
  localparam int TAP_W     = $clog2(TAPS + 1);
  localparam int FCH_W     = (FILTER_CHANNELS > 1) ? $clog2(FILTER_CHANNELS) : 1;
  localparam int HIST_DEPTH = FILTER_CHANNELS * TAPS;
  localparam int HIST_AW   = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int COEF_W    = 28;
  localparam int PROD_W    = COEF_W + 25;
  localparam int UP_SH     = (COEF_FRAC_BITS >= 20) ? COEF_FRAC_BITS - 20 : 0;
  localparam int DN_SH     = (COEF_FRAC_BITS < 20) ? 20 - COEF_FRAC_BITS : 0;
  localparam logic [COEF_W-1:0] DN_RND = (DN_SH > 0) ? (COEF_W'(1) << (DN_SH - 1)) : '0;
  localparam logic signed [63:0] ACC_RND = 64'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic [23:0] SAT24 = 24'hFFFFFF;

  localparam logic [7:0] MARK_BYTE = 8'h80;
  localparam logic [7:0] END_BYTE  = 8'h00;

  localparam logic RK_SAMPLE = 1'b0;
  localparam logic RK_ERR    = 1'b1;

  localparam logic [1:0] CFG_FILTER_EN = 2'd0;
  localparam logic [1:0] CFG_DECIM     = 2'd1;
  localparam logic [1:0] CFG_CHANNELS  = 2'd2;

  // One command word from the parser to the filter engine.
  typedef struct packed {
    logic        is_err;
    logic        has_sample;
    logic [1:0]  chan;
    logic [23:0] value;
    logic        filt;
    logic        dec_hit;
    logic        emit;
  } op_t;

  localparam logic signed [17:0] Q20_HALF [0:HALF_COEF-1] = '{
    18'sd1075, 18'sd456, 18'sd485, 18'sd456, 18'sd351, 18'sd153, -18'sd151, -18'sd570,
    -18'sd1107, -18'sd1757, -18'sd2505, -18'sd3328, -18'sd4190, -18'sd5047, -18'sd5842,
    -18'sd6512, -18'sd6988, -18'sd7197, -18'sd7064, -18'sd6519, -18'sd5500, -18'sd3954,
    -18'sd1843, 18'sd851, 18'sd4130, 18'sd7967, 18'sd12317, 18'sd17111, 18'sd22254,
    18'sd27636, 18'sd33127, 18'sd38587, 18'sd43868, 18'sd48821, 18'sd53301, 18'sd57175,
    18'sd60320, 18'sd62641, 18'sd64064, 18'sd64544
  };

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [TAP_W-1:0] i);
    logic signed [COEF_W-1:0] q;
    logic [COEF_W-1:0] mag;
    int j;
    if (int'(i) >= NUM_COEF) return '0;
    j = (int'(i) < HALF_COEF) ? int'(i) : NUM_COEF - 1 - int'(i);
    q = COEF_W'(Q20_HALF[j]);
    if (COEF_FRAC_BITS >= 20) return q <<< UP_SH;
    mag = q[COEF_W-1] ? COEF_W'(-q) : COEF_W'(q);
    mag = (mag + DN_RND) >> DN_SH;
    return q[COEF_W-1] ? -$signed(mag) : $signed(mag);
  endfunction
endpackage
`default_nettype wire

// ===== design/mfsd_ram.sv =====
// Generic simple dual-port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mfsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 316
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/mfsd_front.sv =====
// Byte parser: marker search, sequence check, sample assembly, decimation.
// Depends on mfsd_pkg; emits command words into the queue.
`default_nettype none
module mfsd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             filter_enable,
  input  wire logic [9:0]       decim_ratio,
  input  wire logic [3:0]       channel_count,
  input  wire logic             q_full,
  output logic                  q_push,
  output mfsd_pkg::op_t         q_op
);
  import mfsd_pkg::*;

  logic [1:0] sync_r, sync_nxt;
  logic       in_pkt_r, in_pkt_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [7:0] lo_r, lo_nxt, mid_r, mid_nxt;
  logic [7:0] exp_r, exp_nxt;
  logic       first_r, first_nxt;
  logic [9:0] phase_r, phase_nxt;

  logic [3:0] cc;
  logic [9:0] ratio;
  logic       dec_hit;
  logic [4:0] cnt, end_idx, kk, ph;
  logic [9:0] k_prod;
  logic [7:0] want;

  assign in_ready = !q_full;

  always_comb begin
    sync_nxt = sync_r; in_pkt_nxt = in_pkt_r; idx_nxt = idx_r;
    lo_nxt = lo_r; mid_nxt = mid_r; exp_nxt = exp_r; first_nxt = first_r;
    phase_nxt = phase_r;
    q_op = '0;
    cc = (channel_count < 4'd2) ? 4'd2 : ((channel_count > 4'd8) ? 4'd8 : channel_count);
    ratio = (decim_ratio == 10'd0) ? 10'd1 : decim_ratio;
    dec_hit = (phase_r == 10'd0);
    cnt = idx_r - 5'd2;
    // Divide by three via multiply by 11/32, exact for these small values.
    k_prod = 10'(cnt) * 10'd11;
    kk = k_prod[9:5];
    ph = cnt - 5'(kk * 5'd3);
    end_idx = 5'(cc) * 5'd3 - 5'd2;
    want = (sync_r == 2'd3) ? END_BYTE : MARK_BYTE;
    if (in_valid && in_ready) begin
      if (!in_pkt_r) begin
        if (in_rx_byte == want) begin
          if (sync_r == 2'd3) begin
            in_pkt_nxt = 1'b1; sync_nxt = 2'd0; idx_nxt = 5'd0;
          end else begin
            sync_nxt = sync_r + 2'd1;
          end
        end else if (in_rx_byte != MARK_BYTE) begin
          sync_nxt = 2'd0;
        end
      end else begin
        if (idx_r == 5'd1) begin
          q_op.is_err = !first_r && (exp_r != in_rx_byte);
          exp_nxt = in_rx_byte + 8'd1;
          first_nxt = 1'b0;
        end else if (idx_r >= 5'd2) begin
          if (ph == 5'd0) begin
            lo_nxt = in_rx_byte;
          end else if (ph == 5'd1) begin
            mid_nxt = in_rx_byte;
          end else if (kk < 5'd4) begin
            q_op.has_sample = 1'b1;
            q_op.chan = kk[1:0];
            q_op.value = {in_rx_byte, mid_r, lo_r};
            q_op.filt = filter_enable && (int'(kk) < FILTER_CHANNELS);
          end
        end
        q_op.dec_hit = dec_hit;
        if (idx_r == end_idx) begin
          q_op.emit = dec_hit;
          phase_nxt = (11'(phase_r) + 11'd1 >= 11'(ratio)) ? 10'd0 : phase_r + 10'd1;
          in_pkt_nxt = 1'b0;
          idx_nxt = 5'd0;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end
    end
    q_push = q_op.is_err || q_op.has_sample || q_op.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= '0; in_pkt_r <= 1'b0; idx_r <= '0; lo_r <= '0; mid_r <= '0;
      exp_r <= '0; first_r <= 1'b1; phase_r <= '0;
    end else begin
      sync_r <= sync_nxt; in_pkt_r <= in_pkt_nxt; idx_r <= idx_nxt;
      lo_r <= lo_nxt; mid_r <= mid_nxt; exp_r <= exp_nxt; first_r <= first_nxt;
      phase_r <= phase_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/mfsd_queue.sv =====
// Four-entry command queue between parser and filter engine.
// Depends on mfsd_pkg for the command word type.
`default_nettype none
module mfsd_queue (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  mfsd_pkg::op_t  din,
  input  wire logic      pop,
  output mfsd_pkg::op_t  dout,
  output logic           full,
  output logic           empty
);
  import mfsd_pkg::*;

  op_t        mem_r [0:3];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + 3'(push && !full) - 3'(pop && !empty);
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 2'd1;
      if (pop && !empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_q_count_range, cnt_r > 3'd4)
  `ASSERT_IMPL(a_q_ptr_gap, empty || full, wp_r == rp_r)
  `ASSERT_IMPL(a_q_ptr_sep, !empty && !full, wp_r != rp_r)
endmodule
`default_nettype wire

// ===== design/mfsd_back.sv =====
// Filter engine: history ring per channel, serial FIR MAC, latching, results.
// Depends on mfsd_pkg and mfsd_ram; fed by mfsd_queue.
`default_nettype none
module mfsd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  mfsd_pkg::op_t    q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [23:0]      out_chan_a,
  output logic [23:0]      out_chan_b,
  output logic [23:0]      out_chan_c,
  output logic [23:0]      out_chan_d
);
  import mfsd_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_EXEC = 3'd1;
  localparam logic [2:0] B_MAC  = 3'd2;
  localparam logic [2:0] B_FIN  = 3'd3;
  localparam logic [2:0] B_EMIT = 3'd4;

  logic [2:0]  state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [TAP_W-1:0] fill_r [0:FILTER_CHANNELS-1];
  logic [TAP_W-1:0] ptr_r  [0:FILTER_CHANNELS-1];
  logic [TAP_W-1:0] fill_new, ptr_new;
  logic [23:0] lat_r [0:3];
  logic [23:0] lat_val;
  logic        lat_we;
  logic        ring_upd;
  logic [TAP_W-1:0] issue_r, issue_nxt, rd_ptr_r, rd_ptr_nxt;
  logic        issuing_r, issuing_nxt, v1_r, v2_r;
  logic signed [COEF_W-1:0] coef_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [63:0] acc_r, acc_nxt, sum;
  logic [63:0] shifted;
  logic        ov_r, ov_nxt, load_out;
  logic [FCH_W-1:0] fch;
  logic [HIST_AW-1:0] base, waddr, raddr;
  logic        ram_we;
  logic [23:0] ram_rdata;

  assign fch  = op_r.chan[FCH_W-1:0];
  assign base = HIST_AW'(fch) * HIST_AW'(TAPS);
  assign waddr = base + HIST_AW'(ptr_r[fch]);
  assign raddr = base + HIST_AW'(rd_ptr_r);
  assign fill_new = (int'(fill_r[fch]) < TAPS) ? fill_r[fch] + 1'b1 : fill_r[fch];
  assign ptr_new  = (int'(ptr_r[fch]) == TAPS - 1) ? '0 : ptr_r[fch] + 1'b1;

  mfsd_ram #(.WIDTH(24), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(op_r.value),
    .raddr(raddr), .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; q_pop = 1'b0;
    ram_we = 1'b0; ring_upd = 1'b0; lat_we = 1'b0; lat_val = op_r.value;
    issue_nxt = issue_r; rd_ptr_nxt = rd_ptr_r; issuing_nxt = issuing_r;
    acc_nxt = acc_r; load_out = 1'b0;
    ov_nxt = ov_r && !out_ready;
    sum = acc_r + ACC_RND;
    shifted = 64'(sum >>> COEF_FRAC_BITS);
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1; op_nxt = q_head; state_nxt = B_EXEC;
        end
      end
      B_EXEC: begin
        state_nxt = B_EMIT;
        if (op_r.has_sample) begin
          if (op_r.filt) begin
            ram_we = 1'b1; ring_upd = 1'b1;
            if (op_r.dec_hit && int'(fill_new) == TAPS) begin
              rd_ptr_nxt = ptr_new; issue_nxt = '0; issuing_nxt = 1'b1;
              acc_nxt = '0; state_nxt = B_MAC;
            end else begin
              lat_we = 1'b1;
            end
          end else begin
            lat_we = 1'b1;
          end
        end
      end
      B_MAC: begin
        if (issuing_r) begin
          issue_nxt = issue_r + 1'b1;
          rd_ptr_nxt = (int'(rd_ptr_r) == TAPS - 1) ? '0 : rd_ptr_r + 1'b1;
          if (int'(issue_r) == TAPS - 1) issuing_nxt = 1'b0;
        end
        if (v2_r) acc_nxt = acc_r + 64'(prod_r);
        if (!issuing_r && !v1_r && !v2_r) state_nxt = B_FIN;
      end
      B_FIN: begin
        // Round half up, then clamp to the unsigned 24-bit range.
        lat_we = 1'b1;
        if (sum[63]) lat_val = '0;
        else if (shifted > 64'(SAT24)) lat_val = SAT24;
        else lat_val = shifted[23:0];
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (op_r.is_err || op_r.emit) begin
          if (!ov_r || out_ready) begin
            load_out = 1'b1; ov_nxt = 1'b1; state_nxt = B_IDLE;
          end
        end else begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_at(issue_r);
    prod_r <= PROD_W'(coef_r) * $signed({1'b0, ram_rdata});
    op_r <= op_nxt;
    issue_r <= issue_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    acc_r <= acc_nxt;
    if (load_out) begin
      out_result_kind <= op_r.is_err ? RK_ERR : RK_SAMPLE;
      out_chan_a <= op_r.is_err ? 24'd0 : lat_r[0];
      out_chan_b <= op_r.is_err ? 24'd0 : lat_r[1];
      out_chan_c <= op_r.is_err ? 24'd0 : lat_r[2];
      out_chan_d <= op_r.is_err ? 24'd0 : lat_r[3];
    end
    if (!rst_n) begin
      state_r <= B_IDLE; issuing_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; ov_r <= 1'b0;
      for (int c = 0; c < FILTER_CHANNELS; c++) begin
        fill_r[c] <= '0; ptr_r[c] <= '0;
      end
      for (int c = 0; c < 4; c++) lat_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      issuing_r <= issuing_nxt;
      v1_r <= (state_r == B_MAC) && issuing_r;
      v2_r <= v1_r;
      ov_r <= ov_nxt;
      if (ring_upd) begin
        fill_r[fch] <= fill_new; ptr_r[fch] <= ptr_new;
      end
      if (lat_we) lat_r[op_r.chan] <= lat_val;
    end
  end

  assign out_valid = ov_r;

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_mac_needs_filt, state_r == B_MAC, op_r.has_sample && op_r.filt && op_r.dec_hit)
  `ASSERT_IMPL(a_we_only_exec, ram_we, state_r == B_EXEC)
  `ASSERT_IMPL(a_err_zero, ov_r && out_result_kind == RK_ERR, out_chan_a == 24'd0 && out_chan_d == 24'd0)
endmodule
`default_nettype wire

// ===== design/marker_framed_sample_deframer_fir.sv =====
// Top level: configuration registers, parser, command queue and filter engine.
// Depends on mfsd_pkg, mfsd_front, mfsd_queue, mfsd_back (and mfsd_ram below it).
//
//   Channel  Direction  Handshake             Word
//   in_      input      in_valid/in_ready     rx_byte
//   out_     output     out_valid/out_ready   result_kind, chan_a..chan_d
//   cfg_     input      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A byte is taken whenever the four-entry queue has room; bytes that only
// advance framing state take nothing more. A sample word that runs the FIR
// makes one history RAM read per tap in the engine; other words only pass
// through its idle, exec and emit states, plus any wait for the output register.
// Reset is synchronous and clears all control state; the history RAM needs no
// clearing since only filled entries are read. A stalled result holds in the
// output register while the parser keeps accepting bytes until the queue fills.
`default_nettype none
module marker_framed_sample_deframer_fir (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_kind,
  output logic [23:0]      out_chan_a,
  output logic [23:0]      out_chan_b,
  output logic [23:0]      out_chan_c,
  output logic [23:0]      out_chan_d,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import mfsd_pkg::*;

  logic       filt_en_r;
  logic [9:0] decim_r;
  logic [3:0] chans_r;
  logic       q_push, q_pop, q_full, q_empty;
  op_t        q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_en_r <= 1'b1; decim_r <= 10'd20; chans_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_EN: filt_en_r <= cfg_data[0];
        CFG_DECIM:     decim_r <= cfg_data;
        CFG_CHANNELS:  chans_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  mfsd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_rx_byte(in_rx_byte), .filter_enable(filt_en_r), .decim_ratio(decim_r),
    .channel_count(chans_r), .q_full(q_full), .q_push(q_push), .q_op(q_in)
  );

  mfsd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_in), .pop(q_pop),
    .dout(q_head), .full(q_full), .empty(q_empty)
  );

  mfsd_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_chan_a(out_chan_a), .out_chan_b(out_chan_b), .out_chan_c(out_chan_c),
    .out_chan_d(out_chan_d)
  );
endmodule
`default_nettype wire
